// ----- rtl/core/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared command and status codes for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_POP_BACK   = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_DELETE     = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

endpackage

// ----- rtl/core/bdq_ram.sv -----
// ----------------------------------------------------------------------------
// bdq_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/bounded_deque_with_delete_top.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_delete_top
// Bounded double-ended queue with delete of the first matching entry.
// ----------------------------------------------------------------------------
// The entries live in a circular buffer in one RAM with a registered read
// port; a head pointer and a count locate the front and the back. One
// request is handled at a time. A push and a refused or unknown request go
// from S_IDLE to S_DONE; a pop passes S_READ and then S_DONE. A delete reads
// the entries from the front one per cycle until it finds a match or reaches
// the back, then moves each entry behind the match one place forward, one
// per cycle. A new request is taken while a finished result still waits on
// the output.
module bounded_deque_with_delete_top #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bdq_pkg::CMD_W-1:0]     in_command,
  input  logic [bdq_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bdq_pkg::VALUE_W-1:0]   out_popped_value,
  output logic [bdq_pkg::OCC_W-1:0]     out_occupancy,
  output logic [bdq_pkg::STATUS_W-1:0]  out_status
);
  import bdq_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = CW + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_SCAN, S_SHIFT, S_DONE} state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [DATA_WIDTH-1:0] res_pop_r, res_pop_nxt;
  status_t               res_st_r, res_st_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    out_pop_r, out_pop_nxt;
  logic [OCC_W-1:0]      out_occ_r, out_occ_nxt;
  status_t               out_st_r, out_st_nxt;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data, in_val;
  logic                  accept, out_free;

  // Physical RAM address of the entry at a logical position from the front.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd,
                                         input logic [CW-1:0] pos);
    logic [PW-1:0] s;
    s = PW'(hd) + PW'(pos);
    if (s >= PW'(CAPACITY)) begin
      s = s - PW'(CAPACITY);
    end
    return AW'(s);
  endfunction

  bdq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_val   = DATA_WIDTH'(in_value);
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    res_pop_nxt   = res_pop_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_pop_nxt   = out_pop_r;
    out_occ_nxt   = out_occ_r;
    out_st_nxt    = out_st_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = in_val;
    rd_addr       = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt     = in_val;
          res_pop_nxt = '0;
          res_st_nxt  = ST_OK;
          idx_nxt     = '0;
          state_nxt   = S_DONE;
          case (in_command)
            CMD_PUSH_BACK: begin
              if (count_r == CAP_C) begin
                res_st_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = phys(head_r, count_r);
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_PUSH_FRONT: begin
              if (count_r == CAP_C) begin
                res_st_nxt = ST_FULL;
              end else begin
                head_nxt  = (head_r == '0) ? AW'(CAPACITY - 1) : head_r - 1'b1;
                wr_en     = 1'b1;
                wr_addr   = head_nxt;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_POP_BACK: begin
              if (count_r == '0) begin
                res_st_nxt = ST_EMPTY;
              end else begin
                rd_addr   = phys(head_r, count_r - 1'b1);
                count_nxt = count_r - 1'b1;
                state_nxt = S_READ;
              end
            end
            CMD_POP_FRONT: begin
              if (count_r == '0) begin
                res_st_nxt = ST_EMPTY;
              end else begin
                rd_addr   = head_r;
                head_nxt  = phys(head_r, CW'(1));
                count_nxt = count_r - 1'b1;
                state_nxt = S_READ;
              end
            end
            CMD_DELETE: begin
              if (count_r == '0) begin
                res_st_nxt = ST_NOMATCH;
              end else begin
                rd_addr   = head_r;
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_pop_nxt = rd_data;
        state_nxt   = S_DONE;
      end
      S_SCAN: begin
        // rd_data holds the entry at position idx_r.
        if (rd_data == val_r) begin
          if (idx_r + 1'b1 == count_r) begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_DONE;
          end else begin
            rd_addr   = phys(head_r, idx_r + 1'b1);
            state_nxt = S_SHIFT;
          end
        end else if (idx_r + 1'b1 == count_r) begin
          res_st_nxt = ST_NOMATCH;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          rd_addr = phys(head_r, idx_r + 1'b1);
        end
      end
      S_SHIFT: begin
        // rd_data holds the entry at idx_r + 1; move it down one place.
        wr_en   = 1'b1;
        wr_addr = phys(head_r, idx_r);
        wr_data = rd_data;
        idx_nxt = idx_r + 1'b1;
        if (CW'(idx_r + 2'd2) == count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_addr = phys(head_r, CW'(idx_r + 2'd2));
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pop_nxt   = VALUE_W'(res_pop_r);
          out_occ_nxt   = OCC_W'(count_r);
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    res_pop_r <= res_pop_nxt;
    res_st_r  <= res_st_nxt;
    out_pop_r <= out_pop_nxt;
    out_occ_r <= out_occ_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_pop_r;
  assign out_occupancy    = out_occ_r;
  assign out_status       = out_st_r;

endmodule

// ----- rtl/core/bdq_checker.sv -----
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks for the bounded deque, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [bdq_pkg::VALUE_W-1:0]   out_popped_value,
  input logic [bdq_pkg::OCC_W-1:0]     out_occupancy,
  input logic [bdq_pkg::STATUS_W-1:0]  out_status
);
  import bdq_pkg::*;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_occupancy) <= CAPACITY)
    else $error("occupancy above capacity");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> 32'(out_occupancy) == CAPACITY)
    else $error("full status while not full");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_occupancy == '0 && out_popped_value == '0)
    else $error("empty status with entries or data");

  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_popped_value != '0 |-> out_status == ST_OK)
    else $error("popped data on a failed request");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_popped_value)
      && $stable(out_occupancy) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind bounded_deque_with_delete_top bdq_checker #(.CAPACITY(CAPACITY)) u_bdq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_popped_value (out_popped_value),
  .out_occupancy    (out_occupancy),
  .out_status       (out_status)
);
